>>> rtl/buzzer_melody_sequencer_unit_defines.svh
// ---------------------------------------------------------------------------
// Buzzer melody sequencer assertion macros
// Shorthand for the clocked, reset-qualified checks of the top level.
// ---------------------------------------------------------------------------
`ifndef BUZZER_MELODY_SEQUENCER_UNIT_DEFINES_SVH
`define BUZZER_MELODY_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, ignored while rst is high.
`define BMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, ignored while rst is high.
`define BMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bms_pkg.sv
// ---------------------------------------------------------------------------
// bms_pkg
// Types and codes shared by the buzzer melody sequencer modules.
// ---------------------------------------------------------------------------
package bms_pkg;

  localparam int unsigned ADDR_W = 6;   // width of address fields and start registers
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned PER_W  = 16;
  localparam int unsigned CMP_W  = 15;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_EVENT = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [0:0] {
    PH_IDLE    = 1'b0,
    PH_PLAYING = 1'b1
  } phase_t;

  // Sound event codes
  localparam logic [2:0] EVT_START       = 3'd0;
  localparam logic [2:0] EVT_KEY_OK      = 3'd1;
  localparam logic [2:0] EVT_KEY_REJECT  = 3'd2;
  localparam logic [2:0] EVT_ENC_OK      = 3'd3;
  localparam logic [2:0] EVT_ENC_ILLEGAL = 3'd4;
  localparam logic [2:0] EVT_SET_OK      = 3'd5;
  localparam logic [2:0] EVT_SET_ILLEGAL = 3'd6;
  localparam logic [2:0] EVT_DONE        = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND_ON              = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_KEY_CONFIRM     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_KEY_REJECT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ENCODER_CONFIRM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ENCODER_ILLEGAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SETTING_CONFIRM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SETTING_ILLEGAL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CYCLES_DONE     = 3'd7;

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic [PER_W-1:0] period;
  } tone_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [2:0]        event_code;
    logic [ADDR_W-1:0] table_address;
    logic [DUR_W-1:0]  tone_duration;
    logic [PER_W-1:0]  note_period;
  } item_t;

  typedef struct packed {
    logic             buzzer_on;
    logic [PER_W-1:0] period_out;
    logic [CMP_W-1:0] compare_out;
    logic             busy_res;
  } result_t;

endpackage

>>> rtl/bms_cfg_regs.sv
// ---------------------------------------------------------------------------
// bms_cfg_regs
// Configuration registers and event-code to melody start address lookup.
// ---------------------------------------------------------------------------
module bms_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [bms_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [bms_pkg::ADDR_W-1:0]     wr_data,
  input  logic [2:0]                     event_code,
  output logic                           sound_on,
  output logic [bms_pkg::ADDR_W-1:0]     event_start
);
  import bms_pkg::*;

  logic [ADDR_W-1:0] start_key_confirm;
  logic [ADDR_W-1:0] start_key_reject;
  logic [ADDR_W-1:0] start_encoder_confirm;
  logic [ADDR_W-1:0] start_encoder_illegal;
  logic [ADDR_W-1:0] start_setting_confirm;
  logic [ADDR_W-1:0] start_setting_illegal;
  logic [ADDR_W-1:0] start_cycles_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_on              <= 1'b1;
      start_key_confirm     <= '0;
      start_key_reject      <= '0;
      start_encoder_confirm <= '0;
      start_encoder_illegal <= '0;
      start_setting_confirm <= '0;
      start_setting_illegal <= '0;
      start_cycles_done     <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_SOUND_ON:              sound_on              <= wr_data[0];
        CFG_START_KEY_CONFIRM:     start_key_confirm     <= wr_data;
        CFG_START_KEY_REJECT:      start_key_reject      <= wr_data;
        CFG_START_ENCODER_CONFIRM: start_encoder_confirm <= wr_data;
        CFG_START_ENCODER_ILLEGAL: start_encoder_illegal <= wr_data;
        CFG_START_SETTING_CONFIRM: start_setting_confirm <= wr_data;
        CFG_START_SETTING_ILLEGAL: start_setting_illegal <= wr_data;
        CFG_START_CYCLES_DONE:     start_cycles_done     <= wr_data;
      endcase
    end
  end

  // Start and key ok share one melody.
  always_comb begin
    unique case (event_code) inside
      EVT_START, EVT_KEY_OK: event_start = start_key_confirm;
      EVT_KEY_REJECT:        event_start = start_key_reject;
      EVT_ENC_OK:            event_start = start_encoder_confirm;
      EVT_ENC_ILLEGAL:       event_start = start_encoder_illegal;
      EVT_SET_OK:            event_start = start_setting_confirm;
      EVT_SET_ILLEGAL:       event_start = start_setting_illegal;
      EVT_DONE:              event_start = start_cycles_done;
      default:               event_start = start_key_confirm;
    endcase
  end

endmodule

>>> rtl/bms_tone_mem.sv
// ---------------------------------------------------------------------------
// bms_tone_mem
// Tone memory: one write port, one registered read port with write bypass.
// ---------------------------------------------------------------------------
module bms_tone_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  bms_pkg::tone_t  wr_data,
  input  logic [AW-1:0]   rd_addr,
  output bms_pkg::tone_t  rd_data
);
  import bms_pkg::*;

  tone_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A same-cycle write to the read address returns the new entry.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/bms_seq_core.sv
// ---------------------------------------------------------------------------
// bms_seq_core
// Sequencer state and the single-pass next-state logic for one transaction.
// ---------------------------------------------------------------------------
module bms_seq_core #(
  parameter int unsigned TONE_DEPTH = 64,
  parameter int unsigned AW         = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  bms_pkg::item_t              item,
  input  logic                        sound_on,
  input  logic [bms_pkg::ADDR_W-1:0]  event_start,
  output logic                        mem_wr_en,
  output logic [AW-1:0]               mem_wr_addr,
  output bms_pkg::tone_t              mem_wr_data,
  output logic [AW-1:0]               mem_rd_addr,
  input  bms_pkg::tone_t              mem_rd_data,
  output bms_pkg::result_t            result_next
);
  import bms_pkg::*;

  localparam int unsigned LUT_N = 1 << ADDR_W;

  // Constant reduction of a 6-bit address modulo the memory depth.
  logic [AW-1:0] wrap_lut [LUT_N];
  for (genvar i = 0; i < LUT_N; i++) begin : g_wrap
    assign wrap_lut[i] = AW'(i % TONE_DEPTH);
  end

  phase_t            phase, phase_next;
  logic [DUR_W-1:0]  ticks_left, ticks_left_next;
  logic [AW-1:0]     tone_index, tone_index_next;
  logic              pending_valid, pending_valid_next;
  logic [AW-1:0]     pending_start, pending_start_next;
  logic              sounding, sounding_next;
  logic [PER_W-1:0]  current_period, current_period_next;

  logic              fetch;
  logic [AW-1:0]     fetch_idx;
  logic [DUR_W-1:0]  ticks_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      ticks_left     <= '0;
      tone_index     <= '0;
      pending_valid  <= 1'b0;
      pending_start  <= '0;
      sounding       <= 1'b0;
      current_period <= '0;
    end else begin
      phase          <= phase_next;
      ticks_left     <= ticks_left_next;
      tone_index     <= tone_index_next;
      pending_valid  <= pending_valid_next;
      pending_start  <= pending_start_next;
      sounding       <= sounding_next;
      current_period <= current_period_next;
    end
  end

  assign fetch_idx = pending_valid ? pending_start : tone_index;
  assign ticks_dec = ticks_left - DUR_W'(1);

  always_comb begin
    phase_next          = phase;
    ticks_left_next     = ticks_left;
    tone_index_next     = tone_index;
    pending_valid_next  = pending_valid;
    pending_start_next  = pending_start;
    sounding_next       = sounding;
    current_period_next = current_period;
    fetch               = 1'b0;
    mem_wr_en           = 1'b0;
    mem_wr_addr         = wrap_lut[item.table_address];
    mem_wr_data         = '{duration: item.tone_duration, period: item.note_period};

    if (accept) begin
      case (op_t'(item.operation))
        OP_TICK: begin
          // A pending request overrides whatever is playing.
          if (pending_valid) begin
            pending_valid_next = 1'b0;
            fetch              = 1'b1;
          end else if (phase == PH_PLAYING) begin
            ticks_left_next = ticks_dec;
            fetch           = (ticks_dec == '0);
          end
          if (fetch) begin
            tone_index_next = (fetch_idx == AW'(TONE_DEPTH - 1)) ? '0 : fetch_idx + AW'(1);
            if (mem_rd_data.duration != '0) begin
              if (mem_rd_data.period != '0) begin
                current_period_next = mem_rd_data.period;
                sounding_next       = 1'b1;
              end else begin
                sounding_next = 1'b0;
              end
              ticks_left_next = mem_rd_data.duration;
              phase_next      = PH_PLAYING;
            end else begin
              phase_next    = PH_IDLE;
              sounding_next = 1'b0;
            end
          end
        end
        OP_EVENT: begin
          if (sound_on) begin
            pending_start_next = wrap_lut[event_start];
            pending_valid_next = 1'b1;
          end
        end
        OP_WRITE: begin
          mem_wr_en = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Prefetch the entry the next tick would read.
  assign mem_rd_addr = rst ? '0 : (pending_valid_next ? pending_start_next : tone_index_next);

  assign result_next.buzzer_on   = sounding_next;
  assign result_next.period_out  = current_period_next;
  assign result_next.compare_out = sounding_next ? current_period_next[PER_W-1:1] : '0;
  assign result_next.busy_res    = (phase_next == PH_PLAYING);

endmodule

>>> rtl/buzzer_melody_sequencer_unit.sv
// ---------------------------------------------------------------------------
// buzzer_melody_sequencer_unit
// Plays melodies from a tone memory on a buzzer, one transaction per cycle unless the output stalls.
// ---------------------------------------------------------------------------
// Every accepted transaction (tick, sound event or tone memory write) gives
// exactly one result showing the buzzer state after it: buzzer_on, the timer
// period, the half-period compare value and the busy flag. The unit takes
// one transaction per clock and the result appears in the output register
// in the cycle after acceptance; item_stall rises only while a result is held
// by result_stall, or during reset. The rate is set by the tone memory,
// which has one registered read port: the entry the next tick will need is
// read every cycle from the state the current transaction leaves, with a
// same-cycle write forwarded, so a tick never waits on the memory. Entries
// are undefined after reset until written; melody start addresses, write
// addresses and the tone index wrap at TONE_DEPTH. Write the configuration
// registers only while no transaction is in flight.
// ---------------------------------------------------------------------------
module buzzer_melody_sequencer_unit #(
  parameter int unsigned TONE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  bms_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output bms_pkg::result_t               result,
  input  logic                           wr_en,
  input  logic [bms_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [bms_pkg::ADDR_W-1:0]     wr_data
);
  import bms_pkg::*;

  `include "buzzer_melody_sequencer_unit_defines.svh"

  localparam int unsigned AW = (TONE_DEPTH > 1) ? $clog2(TONE_DEPTH) : 1;

  logic              accept;
  logic              sound_on;
  logic [ADDR_W-1:0] event_start;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  tone_t             mem_wr_data;
  logic [AW-1:0]     mem_rd_addr;
  tone_t             mem_rd_data;
  result_t           result_next;

  // Hold new transactions during reset and while the output register is full and stalled.
  assign item_stall = rst | (result_valid & result_stall);
  assign accept     = item_valid & ~item_stall;

  bms_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .event_code (item.event_code),
    .sound_on   (sound_on),
    .event_start(event_start)
  );

  bms_tone_mem #(
    .DEPTH(TONE_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  bms_seq_core #(
    .TONE_DEPTH(TONE_DEPTH),
    .AW        (AW)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .sound_on   (sound_on),
    .event_start(event_start),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .result_next(result_next)
  );

  // Output register: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  // Every accepted transaction shows up as a result in the next cycle.
  `BMS_ASSERT_NEXT(a_result_follows, accept, result_valid, "accepted transaction gave no result")
  // A sounding buzzer always carries half its period as compare value.
  `BMS_ASSERT_NOW(a_compare_half, result_valid && result.buzzer_on, result.compare_out == result.period_out[PER_W-1:1], "compare is not half the period")
  // Silence forces a zero compare value.
  `BMS_ASSERT_NOW(a_silent_zero, result_valid && !result.buzzer_on, result.compare_out == '0, "compare nonzero while silent")
  // The buzzer only sounds while a melody is playing.
  `BMS_ASSERT_NOW(a_sound_busy, result_valid && result.buzzer_on, result.busy_res, "buzzer on while sequencer idle")

endmodule
